>>> hdl/ogi_pkg.sv
// shared types, constants and codes of the occupancy grid inflation block
`timescale 1ns / 1ps
package ogi_pkg;

    // grid geometry
    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int MAX_RADIUS = 8;

    localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);

    localparam logic [8:0] MAX_ROWS_C   = 9'(MAX_ROWS);
    localparam logic [8:0] MAX_COLS_C   = 9'(MAX_COLS);
    localparam logic [3:0] MAX_RADIUS_C = 4'(MAX_RADIUS);

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // cell classes
    localparam logic [1:0] CLASS_FREE     = 2'd0;
    localparam logic [1:0] CLASS_OCCUPIED = 2'd1;
    localparam logic [1:0] CLASS_UNKNOWN  = 2'd2;
    localparam logic [1:0] CLASS_INVALID  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [1:0] REG_GRID_COLS = 2'd1;
    localparam logic [1:0] REG_RADIUS    = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] row;
        logic [7:0] col;
        logic [1:0] cell_class;
    } item_t;

    typedef struct packed {
        logic [1:0] inflated_class;
        logic       out_of_range;
    } result_t;

    // saturated configuration seen by the sequencer
    typedef struct packed {
        logic [8:0] rows;
        logic [8:0] cols;
        logic [3:0] radius;
    } cfg_eff_t;

    // grid memory access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [1:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> hdl/ogi_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module ogi_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ogi_cfg.sv
// configuration registers with saturation to the grid limits
`timescale 1ns / 1ps
module ogi_cfg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [8:0]      cfg_data,
    output ogi_pkg::cfg_eff_t cfg
);
    import ogi_pkg::*;

    logic [8:0] grid_rows_reg;
    logic [8:0] grid_cols_reg;
    logic [3:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= 9'd256;
            grid_cols_reg <= 9'd256;
            radius_reg    <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                REG_RADIUS:    radius_reg    <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    assign cfg.rows   = (grid_rows_reg > MAX_ROWS_C) ? MAX_ROWS_C : grid_rows_reg;
    assign cfg.cols   = (grid_cols_reg > MAX_COLS_C) ? MAX_COLS_C : grid_cols_reg;
    assign cfg.radius = (radius_reg > MAX_RADIUS_C) ? MAX_RADIUS_C : radius_reg;

    a_cfg_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.rows <= MAX_ROWS_C && cfg.cols <= MAX_COLS_C && cfg.radius <= MAX_RADIUS_C)
        else $error("saturated configuration out of limits");

endmodule

>>> hdl/ogi_seq.sv
// command sequencer: cell writes, window scan over the grid memory, result register
`timescale 1ns / 1ps
module ogi_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ogi_pkg::item_t    item,
    input  ogi_pkg::cfg_eff_t cfg,
    input  logic [1:0]        rdata,
    output logic              busy,
    output logic              done,
    output ogi_pkg::result_t  result,
    output ogi_pkg::mem_req_t mem
);
    import ogi_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       own_pend_reg, own_pend_next;
    logic       scan_pend_reg, scan_pend_next;
    logic       done_reg, done_next;
    result_t    result_reg, result_next;
    logic [7:0] sr_reg, sr_next;
    logic [7:0] sc_reg, sc_next;
    logic [7:0] r_hi_reg, r_hi_next;
    logic [7:0] c_lo_reg, c_lo_next;
    logic [7:0] c_hi_reg, c_hi_next;
    logic       hit_reg, hit_next;
    logic [1:0] own_reg, own_next;

    logic       accept;
    logic       in_grid;
    logic [8:0] rad9;
    logic [8:0] row_p1, col_p1;
    logic [8:0] row_hi9, col_hi9;
    logic [8:0] row_lim, col_lim;
    logic [7:0] r_lo, c_lo, r_hi, c_hi;
    logic       hit_now;
    logic [1:0] own_now;

    assign accept  = start && !busy;
    assign in_grid = ({1'b0, item.row} < cfg.rows) && ({1'b0, item.col} < cfg.cols);

    // window bounds, clipped to the grid in use
    assign rad9    = {5'd0, cfg.radius};
    assign row_p1  = {1'b0, item.row} + 9'd1;
    assign col_p1  = {1'b0, item.col} + 9'd1;
    assign row_hi9 = {1'b0, item.row} + rad9;
    assign col_hi9 = {1'b0, item.col} + rad9;
    assign row_lim = cfg.rows - 9'd1;
    assign col_lim = cfg.cols - 9'd1;
    assign r_lo    = (row_p1 < rad9) ? 8'd0 : 8'(row_p1 - rad9);
    assign c_lo    = (col_p1 < rad9) ? 8'd0 : 8'(col_p1 - rad9);
    assign r_hi    = (row_hi9 > row_lim) ? row_lim[7:0] : row_hi9[7:0];
    assign c_hi    = (col_hi9 > col_lim) ? col_lim[7:0] : col_hi9[7:0];

    assign hit_now = hit_reg || (scan_pend_reg && rdata == CLASS_OCCUPIED);
    assign own_now = own_pend_reg ? rdata : own_reg;

    // memory access: writes land at acceptance, reads follow the scan
    assign mem.we    = accept && item.opcode == OP_WRITE && in_grid;
    assign mem.waddr = {item.row, item.col};
    assign mem.wdata = (item.cell_class == CLASS_INVALID) ? CLASS_UNKNOWN : item.cell_class;
    assign mem.raddr = (state_reg == S_SCAN) ? {sr_reg, sc_reg} : {item.row, item.col};

    always_comb
    begin
        state_next     = state_reg;
        own_pend_next  = accept && item.opcode == OP_QUERY && in_grid;
        scan_pend_next = (state_reg == S_SCAN);
        done_next      = 1'b0;
        result_next    = result_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        r_hi_next      = r_hi_reg;
        c_lo_next      = c_lo_reg;
        c_hi_next      = c_hi_reg;
        hit_next       = hit_now;
        own_next       = own_now;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.opcode == OP_QUERY)
                begin
                    if (!in_grid)
                    begin
                        done_next                  = 1'b1;
                        result_next.inflated_class = CLASS_FREE;
                        result_next.out_of_range   = 1'b1;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        sr_next    = r_lo;
                        sc_next    = c_lo;
                        r_hi_next  = r_hi;
                        c_lo_next  = c_lo;
                        c_hi_next  = c_hi;
                        state_next = (cfg.radius == 4'd0) ? S_WAIT : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (sc_reg == c_hi_reg)
                begin
                    sc_next = c_lo_reg;
                    if (sr_reg == r_hi_reg)
                    begin
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        sr_next = sr_reg + 8'd1;
                    end
                end
                else
                begin
                    sc_next = sc_reg + 8'd1;
                end
            end
            S_WAIT:
            begin
                // last read data is on rdata now
                done_next                  = 1'b1;
                result_next.inflated_class = hit_now ? CLASS_OCCUPIED : own_now;
                result_next.out_of_range   = 1'b0;
                state_next                 = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            own_pend_reg  <= 1'b0;
            scan_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            own_pend_reg  <= own_pend_next;
            scan_pend_reg <= scan_pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        sr_reg     <= sr_next;
        sc_reg     <= sc_next;
        r_hi_reg   <= r_hi_next;
        c_lo_reg   <= c_lo_next;
        c_hi_reg   <= c_hi_next;
        hit_reg    <= hit_next;
        own_reg    <= own_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == OP_QUERY && in_grid) |=> busy)
        else $error("in-grid query did not start a scan");

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (sr_reg <= r_hi_reg && sc_reg >= c_lo_reg
                                   && sc_reg <= c_hi_reg))
        else $error("scan address left the window");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem.we |-> (state_reg == S_IDLE && !own_pend_reg && !scan_pend_reg))
        else $error("grid write during a query");

endmodule

>>> hdl/occupancy_grid_obstacle_inflation_core.sv
// top level of the occupancy grid with square obstacle inflation
`timescale 1ns / 1ps
// a write gives no result; a query outside the grid answers out of range with no scan;
//   one inside scans its clipped window of up to 256 cells, or its own cell at radius zero
// throughput: busy stays high while a query scans, one window cell per cycle through the
//   single grid read port; writes go back to back
// the receiver cannot stall: each result shows for one cycle on done; reset clears control
//   and configuration (256 x 256, radius 0), the grid memory stays undefined until written
module occupancy_grid_obstacle_inflation_core (
    input  logic             clk,
    input  logic             rst_n,
    // command transaction
    input  logic             start,
    output logic             busy,
    input  ogi_pkg::item_t   item,
    // result transaction
    output logic             done,
    output ogi_pkg::result_t result,
    // configuration write port
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_data
);
    import ogi_pkg::*;

    cfg_eff_t   cfg;
    mem_req_t   mem;
    logic [1:0] rdata;

    // register file: grid size and radius, saturated to the limits
    ogi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // grid store, one 2-bit class per cell, addressed row-major
    ogi_ram #(
        .WIDTH (2),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // sequencer: takes each transaction, walks the window and builds the result
    ogi_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .cfg    (cfg),
        .rdata  (rdata),
        .busy   (busy),
        .done   (done),
        .result (result),
        .mem    (mem)
    );

endmodule

>>> verif/occupancy_grid_obstacle_inflation_core_test.sv
// self-checking testbench for the occupancy grid obstacle inflation core
`timescale 1ns / 1ps
module occupancy_grid_obstacle_inflation_core_test;
    import ogi_pkg::*;

    // cycles with no transaction of any kind before the run is called hung;
    // the slowest query keeps the block busy through its whole window scan, plus a sender gap
    localparam int QUIET_LIMIT = 3000;
    // register index past the end of the list, must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 57;

    typedef enum logic {STEP_REG, STEP_CMD} step_kind_t;

    // one line of the directed table: a register write or a command transaction,
    // with the answer typed in where it is obvious
    typedef struct {
        step_kind_t kind;
        item_t      cmd;
        logic [1:0] reg_index;
        logic [8:0] reg_value;
        bit         pinned;
        result_t    pinned_res;
    } plan_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    done;
    result_t result;
    logic    cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    // shadow copy of the grid and of the registers
    logic [1:0] grid_shadow [0:GRID_DEPTH-1];
    bit         grid_known [0:GRID_DEPTH-1];
    logic [8:0] rows_reg = 9'd256;
    logic [8:0] cols_reg = 9'd256;
    logic [3:0] radius_reg = 4'd0;

    result_t pending_answers [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      gaps_on = 1'b0;

    plan_t directed_q [$];
    int    phase_rows [PHASES]   = '{256, 256, 40, 1, 256, 511, 256, 17};
    int    phase_cols [PHASES]   = '{256, 256, 200, 256, 1, 300, 256, 23};
    int    phase_radius [PHASES] = '{8, 0, 9'h1F3, 4, 2, 12, 1, 8};

    occupancy_grid_obstacle_inflation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------------

    // applies one command to the shadow grid; returns 1 when it yields an answer
    function automatic bit inflate_cell(input item_t it, output result_t res);
        int rows_e;
        int cols_e;
        int rad;
        int r_lo;
        int r_hi;
        int c_lo;
        int c_hi;
        bit in_grid;
        bit hit;
        rows_e = (rows_reg > MAX_ROWS_C) ? MAX_ROWS : int'(rows_reg);
        cols_e = (cols_reg > MAX_COLS_C) ? MAX_COLS : int'(cols_reg);
        rad = (radius_reg > MAX_RADIUS_C) ? MAX_RADIUS : int'(radius_reg);
        in_grid = (int'(it.row) < rows_e) && (int'(it.col) < cols_e);
        res = '0;
        if (it.opcode == OP_WRITE)
        begin
            // class three is neither free nor occupied, so it lands as unknown
            if (in_grid)
            begin
                grid_shadow[int'(it.row) * MAX_COLS + int'(it.col)] =
                    (it.cell_class == CLASS_INVALID) ? CLASS_UNKNOWN : it.cell_class;
                grid_known[int'(it.row) * MAX_COLS + int'(it.col)] = 1'b1;
            end
            return 1'b0;
        end
        if (!in_grid)
        begin
            res.inflated_class = CLASS_FREE;
            res.out_of_range = 1'b1;
            return 1'b1;
        end
        // window is lopsided: R-1 cells before the cell, R after, clipped to the grid
        r_lo = int'(it.row) - rad + 1;
        r_hi = int'(it.row) + rad;
        c_lo = int'(it.col) - rad + 1;
        c_hi = int'(it.col) + rad;
        if (r_lo < 0) r_lo = 0;
        if (c_lo < 0) c_lo = 0;
        if (r_hi > rows_e - 1) r_hi = rows_e - 1;
        if (c_hi > cols_e - 1) c_hi = cols_e - 1;
        hit = 1'b0;
        if (rad > 0)
            for (int sr = r_lo; sr <= r_hi; sr++)
                for (int sc = c_lo; sc <= c_hi; sc++)
                    if (grid_shadow[sr * MAX_COLS + sc] == CLASS_OCCUPIED)
                        hit = 1'b1;
        res.inflated_class = hit ? CLASS_OCCUPIED
                                 : grid_shadow[int'(it.row) * MAX_COLS + int'(it.col)];
        res.out_of_range = 1'b0;
        return 1'b1;
    endfunction

    // 1 when the command reads no cell that was never written: writes, queries
    // outside the grid, and queries whose cell and window are all written
    function automatic bit window_known(input item_t it);
        int rows_e;
        int cols_e;
        int rad;
        int r_lo;
        int r_hi;
        int c_lo;
        int c_hi;
        bit known;
        rows_e = (rows_reg > MAX_ROWS_C) ? MAX_ROWS : int'(rows_reg);
        cols_e = (cols_reg > MAX_COLS_C) ? MAX_COLS : int'(cols_reg);
        rad = (radius_reg > MAX_RADIUS_C) ? MAX_RADIUS : int'(radius_reg);
        if (it.opcode == OP_WRITE || int'(it.row) >= rows_e || int'(it.col) >= cols_e)
            return 1'b1;
        known = grid_known[int'(it.row) * MAX_COLS + int'(it.col)];
        r_lo = int'(it.row) - rad + 1;
        r_hi = int'(it.row) + rad;
        c_lo = int'(it.col) - rad + 1;
        c_hi = int'(it.col) + rad;
        if (r_lo < 0) r_lo = 0;
        if (c_lo < 0) c_lo = 0;
        if (r_hi > rows_e - 1) r_hi = rows_e - 1;
        if (c_hi > cols_e - 1) c_hi = cols_e - 1;
        if (rad > 0)
            for (int sr = r_lo; sr <= r_hi; sr++)
                for (int sc = c_lo; sc <= c_hi; sc++)
                    if (!grid_known[sr * MAX_COLS + sc])
                        known = 1'b0;
        return known;
    endfunction

    // ---------------------------------------------------------------------------
    // directed table builders
    // ---------------------------------------------------------------------------

    function automatic plan_t cmd_row(logic op, logic [7:0] r, logic [7:0] c, logic [1:0] cls);
        plan_t p;
        p = '{STEP_CMD, '{op, r, c, cls}, REG_GRID_ROWS, 9'd0, 1'b0, '0};
        return p;
    endfunction

    function automatic plan_t pinned_row(logic [7:0] r, logic [7:0] c,
                                         logic [1:0] want_class, logic want_oor);
        plan_t p;
        p = '{STEP_CMD, '{OP_QUERY, r, c, CLASS_FREE}, REG_GRID_ROWS, 9'd0, 1'b1,
              '{want_class, want_oor}};
        return p;
    endfunction

    function automatic plan_t reg_row(logic [1:0] idx, logic [8:0] val);
        plan_t p;
        p = '{STEP_REG, '0, idx, val, 1'b0, '0};
        return p;
    endfunction

    // ---------------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // drives one command transaction and books its answer once accepted;
    // start stays high on return so back-to-back commands need not lower and raise it
    task automatic issue(input item_t it, input bit pinned, input result_t pinned_res);
        result_t want;
        bit gives;
        if (gaps_on && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        gives = inflate_cell(it, want);
        if (gives)
            pending_answers.push_back(pinned ? pinned_res : want);
    endtask

    // writes a square patch of cells: mostly free, a sprinkle of unknown and rare obstacles
    task automatic preload(input int r0, input int c0, input int span);
        item_t it;
        int    k;
        for (int r = r0; r < r0 + span; r++)
        begin
            for (int c = c0; c < c0 + span; c++)
            begin
                k = $urandom_range(0, 511);
                it.opcode = OP_WRITE;
                it.row = 8'(r);
                it.col = 8'(c);
                it.cell_class = (k == 0) ? CLASS_OCCUPIED
                              : (k < 24) ? CLASS_UNKNOWN
                              : (k == 24) ? CLASS_INVALID : CLASS_FREE;
                issue(it, 1'b0, '0);
            end
        end
    endtask

    // stop sending and let every outstanding answer come home; the extra cycles
    // cover a trailing write, which gives no answer to wait for
    task automatic drain();
        start <= 1'b0;
        while (pending_answers.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves cfg_we high so writes can go back to back; the caller lowers it
    task automatic set_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_GRID_ROWS: rows_reg = val;
            REG_GRID_COLS: cols_reg = val;
            REG_RADIUS:    radius_reg = val[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // coordinate for the random part: mostly a hot patch, else the grid,
    // its edges, or anywhere at all
    function automatic logic [7:0] pick_coord(input int hot, input int lim);
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return 8'(hot + $urandom_range(0, 19));
        if (k < 7) return 8'($urandom_range(0, lim - 1));
        if (k == 7)
        begin
            case ($urandom_range(0, 3))
                0: return 8'd0;
                1: return 8'(lim - 1);
                2: return 8'(lim);
                default: return 8'd255;
            endcase
        end
        return 8'($urandom);
    endfunction

    // ---------------------------------------------------------------------------
    // result check: the receiver takes every result in the cycle it shows
    // ---------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_answers
        result_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d/%0d with no query waiting",
                                        result.inflated_class, result.out_of_range));
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result.inflated_class !== want.inflated_class)
                    flag_mismatch($sformatf("inflated_class %0d, want %0d",
                                            result.inflated_class, want.inflated_class));
                if (result.out_of_range !== want.out_of_range)
                    flag_mismatch($sformatf("out_of_range %0d, want %0d",
                                            result.out_of_range, want.out_of_range));
            end
        end
    end

    // watchdog: any accepted transaction or register write resets the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("occupancy_grid_obstacle_inflation_core_test: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------------
    initial
    begin : stimulus
        item_t   it;
        bit      reg_open;
        int      hot_r;
        int      hot_c;
        int      rows_lim;
        int      cols_lim;
        int      k;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the grid memory comes up undefined: two corner patches are written up front
        // and no query is let near a cell that was never written
        preload(0, 0, 17);
        preload(248, 248, 8);

        // directed part: extremes, saturation, empty grid, ignored writes and indexes
        directed_q = {
            cmd_row(OP_WRITE, 8'd0, 8'd0, CLASS_OCCUPIED),
            cmd_row(OP_WRITE, 8'd255, 8'd255, CLASS_INVALID),
            cmd_row(OP_WRITE, 8'd255, 8'd0, CLASS_UNKNOWN),
            cmd_row(OP_WRITE, 8'd0, 8'd255, CLASS_FREE),
            // radius zero: each query answers the cell's own class
            pinned_row(8'd255, 8'd255, CLASS_UNKNOWN, 1'b0),
            pinned_row(8'd0, 8'd0, CLASS_OCCUPIED, 1'b0),
            pinned_row(8'd0, 8'd255, CLASS_FREE, 1'b0),
            reg_row(REG_RADIUS, 9'd8),
            pinned_row(8'd0, 8'd0, CLASS_OCCUPIED, 1'b0),
            pinned_row(8'd7, 8'd7, CLASS_OCCUPIED, 1'b0),
            pinned_row(8'd8, 8'd8, CLASS_FREE, 1'b0),
            cmd_row(OP_QUERY, 8'd255, 8'd255, CLASS_FREE),
            cmd_row(OP_QUERY, 8'd0, 8'd8, CLASS_INVALID),
            // radius above the top saturates
            reg_row(REG_RADIUS, 9'd15),
            pinned_row(8'd7, 8'd7, CLASS_OCCUPIED, 1'b0),
            cmd_row(OP_QUERY, 8'd8, 8'd0, CLASS_OCCUPIED),
            // grid size above the top saturates
            reg_row(REG_GRID_ROWS, 9'd511),
            reg_row(REG_GRID_COLS, 9'd511),
            cmd_row(OP_QUERY, 8'd255, 8'd255, CLASS_UNKNOWN),
            reg_row(REG_GRID_ROWS, 9'd16),
            reg_row(REG_GRID_COLS, 9'd300),
            reg_row(REG_RADIUS, 9'd1),
            pinned_row(8'd16, 8'd0, CLASS_FREE, 1'b1),
            // write outside the grid must leave the cell alone
            cmd_row(OP_WRITE, 8'd16, 8'd5, CLASS_OCCUPIED),
            cmd_row(OP_QUERY, 8'd15, 8'd5, CLASS_FREE),
            // zero rows: nothing is inside
            reg_row(REG_GRID_ROWS, 9'd0),
            pinned_row(8'd0, 8'd0, CLASS_FREE, 1'b1),
            reg_row(REG_UNUSED, 9'd511),
            reg_row(REG_GRID_ROWS, 9'd1),
            reg_row(REG_GRID_COLS, 9'd1),
            pinned_row(8'd0, 8'd0, CLASS_OCCUPIED, 1'b0),
            pinned_row(8'd0, 8'd1, CLASS_FREE, 1'b1),
            reg_row(REG_GRID_ROWS, 9'd256),
            reg_row(REG_GRID_COLS, 9'd256),
            reg_row(REG_RADIUS, 9'd2),
            // window reaches the cell that the ignored write aimed at
            cmd_row(OP_QUERY, 8'd14, 8'd5, CLASS_FREE),
            pinned_row(8'd1, 8'd1, CLASS_OCCUPIED, 1'b0),
            // a write and a query of the same cell back to back
            reg_row(REG_RADIUS, 9'd0),
            cmd_row(OP_WRITE, 8'd200, 8'd200, CLASS_FREE),
            cmd_row(OP_QUERY, 8'd200, 8'd200, CLASS_FREE)
        };
        // (8,8) at radius 8 is the one pinned cell not read off at a glance: it is
        // overwritten here by a plain query so the answer follows whatever the preload drew
        directed_q[10] = cmd_row(OP_QUERY, 8'd8, 8'd8, CLASS_FREE);

        gaps_on = 1'b1;
        reg_open = 1'b0;
        foreach (directed_q[i])
        begin
            if (directed_q[i].kind == STEP_REG)
            begin
                if (!reg_open) drain();
                set_reg(directed_q[i].reg_index, directed_q[i].reg_value);
                reg_open = 1'b1;
            end
            else
            begin
                if (reg_open)
                begin
                    cfg_we <= 1'b0;
                    reg_open = 1'b0;
                end
                issue(directed_q[i].cmd, directed_q[i].pinned, directed_q[i].pinned_res);
            end
        end

        // random part: each phase waits for the block to empty, then reprograms
        // every register, so the sender also pauses until all answers are back
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            set_reg(REG_GRID_ROWS, 9'(phase_rows[ph]));
            set_reg(REG_GRID_COLS, 9'(phase_cols[ph]));
            set_reg(REG_RADIUS, 9'(phase_radius[ph]));
            if (ph == 3) set_reg(REG_UNUSED, 9'($urandom));
            cfg_we <= 1'b0;
            // one phase runs with no sender gaps at all
            gaps_on = (ph != 4);
            rows_lim = (rows_reg > MAX_ROWS_C) ? MAX_ROWS : int'(rows_reg);
            cols_lim = (cols_reg > MAX_COLS_C) ? MAX_COLS : int'(cols_reg);
            hot_r = $urandom_range(0, rows_lim - 1);
            hot_c = $urandom_range(0, cols_lim - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it.opcode = ($urandom_range(0, 99) < 55) ? OP_QUERY : OP_WRITE;
                it.row = pick_coord(hot_r, rows_lim);
                it.col = pick_coord(hot_c, cols_lim);
                // writes lean toward obstacles so the hot patch fills up
                k = $urandom_range(0, 9);
                it.cell_class = (k < 3) ? CLASS_OCCUPIED
                              : (k < 6) ? CLASS_FREE
                              : (k < 8) ? CLASS_UNKNOWN : CLASS_INVALID;
                // a query that would reach a never-written cell moves into the
                // top-left patch, where every window stays on written cells
                if (!window_known(it))
                begin
                    it.row = it.row & 8'd7;
                    it.col = it.col & 8'd7;
                end
                issue(it, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("occupancy_grid_obstacle_inflation_core_test: clean");
        else
            $display("occupancy_grid_obstacle_inflation_core_test: errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/ogi_pkg.sv
hdl/ogi_ram.sv
hdl/ogi_cfg.sv
hdl/ogi_seq.sv
hdl/occupancy_grid_obstacle_inflation_core.sv
verif/occupancy_grid_obstacle_inflation_core_test.sv
